// ===== hdl/mds_pkg.sv =====
// Shared types and constants of the motor direction sequencer.
// Used by the register file, the core and the top level.
package mds_pkg;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_MODE   = 2'd1,
      OP_SPEED  = 2'd2,
      OP_UPDATE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STAGE_IDLE   = 3'b001,
      STAGE_DIR    = 3'b010,
      STAGE_ENABLE = 3'b100
   } stage_type;

   localparam logic [2:0] MODE_STOP  = 3'd0;
   localparam logic [2:0] MODE_LEFT  = 3'd1;
   localparam logic [2:0] MODE_RIGHT = 3'd2;
   localparam logic [2:0] MODE_FRONT = 3'd3;
   localparam logic [2:0] MODE_BACK  = 3'd4;

   localparam logic [1:0] SPEED_FAST = 2'd2;

   localparam logic [2:0] CFG_STOP_DELAY   = 3'd0;
   localparam logic [2:0] CFG_SIDE_DELAY   = 3'd1;
   localparam logic [2:0] CFG_FRONT_DELAY  = 3'd2;
   localparam logic [2:0] CFG_BACK_DELAY   = 3'd3;
   localparam logic [2:0] CFG_ENABLE_DELAY = 3'd4;
   localparam logic [2:0] CFG_TEMP_LOW     = 3'd5;
   localparam logic [2:0] CFG_TEMP_HIGH    = 3'd6;

   localparam logic [7:0]        RST_STOP_DELAY   = 8'd100;
   localparam logic [7:0]        RST_SIDE_DELAY   = 8'd30;
   localparam logic [7:0]        RST_FRONT_DELAY  = 8'd100;
   localparam logic [7:0]        RST_BACK_DELAY   = 8'd200;
   localparam logic [7:0]        RST_ENABLE_DELAY = 8'd50;
   localparam logic signed [7:0] RST_TEMP_LOW     = -8'sd10;
   localparam logic signed [7:0] RST_TEMP_HIGH    = 8'sd40;

   typedef struct packed {
      logic [7:0]        stop_delay;
      logic [7:0]        side_delay;
      logic [7:0]        front_delay;
      logic [7:0]        back_delay;
      logic [7:0]        enable_delay;
      logic signed [7:0] temp_low;
      logic signed [7:0] temp_high;
   } cfg_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [2:0]        mode;
      logic [1:0]        speed;
      logic signed [7:0] temperature;
   } req_type;

   typedef struct packed {
      logic       pin_left;
      logic       pin_right;
      logic       pin_front;
      logic       pin_back;
      logic       pin_enable;
      logic       pin_high_speed;
      logic [2:0] committed_mode;
      logic [1:0] current_speed_code;
      logic       sequence_busy;
   } rsp_type;

endpackage

// ===== hdl/mds_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Stand-alone; field widths follow mds_pkg.
interface mds_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [2:0]        mode;
   logic [1:0]        speed;
   logic signed [7:0] temperature;

   modport source (output valid, opcode, mode, speed, temperature, input ready);
   modport sink   (input valid, opcode, mode, speed, temperature, output ready);
endinterface

interface mds_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_left;
   logic       pin_right;
   logic       pin_front;
   logic       pin_back;
   logic       pin_enable;
   logic       pin_high_speed;
   logic [2:0] committed_mode;
   logic [1:0] current_speed_code;
   logic       sequence_busy;

   modport source (output valid, pin_left, pin_right, pin_front, pin_back, pin_enable,
                   pin_high_speed, committed_mode, current_speed_code, sequence_busy,
                   input ready);
   modport sink   (input valid, pin_left, pin_right, pin_front, pin_back, pin_enable,
                   pin_high_speed, committed_mode, current_speed_code, sequence_busy,
                   output ready);
endinterface

// ===== hdl/mds_csr.sv =====
// Configuration register file: delays and temperature window.
// Depends on mds_pkg.
module mds_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wr_data,
   output mds_pkg::cfg_type cfg
);

   mds_pkg::cfg_type cfg_ff;
   mds_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mds_pkg::CFG_STOP_DELAY:   cfg_in.stop_delay   = csr_wr_data;
            mds_pkg::CFG_SIDE_DELAY:   cfg_in.side_delay   = csr_wr_data;
            mds_pkg::CFG_FRONT_DELAY:  cfg_in.front_delay  = csr_wr_data;
            mds_pkg::CFG_BACK_DELAY:   cfg_in.back_delay   = csr_wr_data;
            mds_pkg::CFG_ENABLE_DELAY: cfg_in.enable_delay = csr_wr_data;
            mds_pkg::CFG_TEMP_LOW:     cfg_in.temp_low     = csr_wr_data;
            mds_pkg::CFG_TEMP_HIGH:    cfg_in.temp_high    = csr_wr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_delay   <= mds_pkg::RST_STOP_DELAY;
         cfg_ff.side_delay   <= mds_pkg::RST_SIDE_DELAY;
         cfg_ff.front_delay  <= mds_pkg::RST_FRONT_DELAY;
         cfg_ff.back_delay   <= mds_pkg::RST_BACK_DELAY;
         cfg_ff.enable_delay <= mds_pkg::RST_ENABLE_DELAY;
         cfg_ff.temp_low     <= mds_pkg::RST_TEMP_LOW;
         cfg_ff.temp_high    <= mds_pkg::RST_TEMP_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mds_core.sv =====
// Sequencer state and its single-pass update for one request word.
// The state registers double as the response register. Depends on mds_pkg.
module mds_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  mds_pkg::req_type item,
   input  mds_pkg::cfg_type cfg,
   output mds_pkg::rsp_type state
);

   logic [3:0]          dir_ff,   dir_in;
   logic                en_ff,    en_in;
   logic                hs_ff,    hs_in;
   mds_pkg::stage_type  stage_ff, stage_in;
   logic [7:0]          count_ff, count_in;
   logic [2:0]          pmode_ff, pmode_in;
   logic [2:0]          mode_ff,  mode_in;
   logic [1:0]          speed_ff, speed_in;
   logic                busy_ff,  busy_in;

   always_comb begin
      logic       in_window;
      logic [1:0] speed_sel;
      dir_in    = dir_ff;
      en_in     = en_ff;
      hs_in     = hs_ff;
      stage_in  = stage_ff;
      count_in  = count_ff;
      pmode_in  = pmode_ff;
      mode_in   = mode_ff;
      speed_in  = speed_ff;
      busy_in   = busy_ff;
      in_window = (item.temperature >= cfg.temp_low) && (item.temperature <= cfg.temp_high);
      speed_sel = (item.opcode == mds_pkg::OP_SPEED) ? item.speed : speed_ff;
      case (item.opcode)
         mds_pkg::OP_TICK: begin
            if (stage_ff != mds_pkg::STAGE_IDLE) begin
               if (count_ff <= 8'd1) begin
                  count_in = 8'd0;
                  case (stage_ff)
                     mds_pkg::STAGE_DIR: begin
                        case (pmode_ff)
                           mds_pkg::MODE_STOP: begin
                              dir_in   = 4'b0000;
                              en_in    = 1'b0;
                              mode_in  = mds_pkg::MODE_STOP;
                              busy_in  = 1'b0;
                              stage_in = mds_pkg::STAGE_IDLE;
                           end
                           mds_pkg::MODE_LEFT,
                           mds_pkg::MODE_RIGHT,
                           mds_pkg::MODE_FRONT,
                           mds_pkg::MODE_BACK: begin
                              dir_in   = dir_ff | (4'b0001 << (pmode_ff - 3'd1));
                              stage_in = mds_pkg::STAGE_ENABLE;
                              count_in = cfg.enable_delay;
                           end
                           default: stage_in = mds_pkg::STAGE_IDLE;
                        endcase
                     end
                     mds_pkg::STAGE_ENABLE: begin
                        en_in    = 1'b1;
                        mode_in  = pmode_ff;
                        busy_in  = 1'b0;
                        stage_in = mds_pkg::STAGE_IDLE;
                     end
                     default: stage_in = mds_pkg::STAGE_IDLE;
                  endcase
               end else begin
                  count_in = count_ff - 8'd1;
               end
            end
         end
         mds_pkg::OP_MODE: begin
            dir_in   = 4'b0000;
            en_in    = 1'b0;
            busy_in  = 1'b1;
            pmode_in = item.mode;
            stage_in = mds_pkg::STAGE_DIR;
            case (item.mode)
               mds_pkg::MODE_STOP:  count_in = cfg.stop_delay;
               mds_pkg::MODE_LEFT,
               mds_pkg::MODE_RIGHT: count_in = cfg.side_delay;
               mds_pkg::MODE_FRONT: count_in = cfg.front_delay;
               mds_pkg::MODE_BACK:  count_in = cfg.back_delay;
               default: begin
                  stage_in = mds_pkg::STAGE_IDLE;
                  count_in = 8'd0;
               end
            endcase
         end
         mds_pkg::OP_SPEED,
         mds_pkg::OP_UPDATE: begin
            speed_in = speed_sel;
            hs_in    = (speed_sel == mds_pkg::SPEED_FAST) && in_window;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= 4'b0000;
         en_ff    <= 1'b0;
         hs_ff    <= 1'b0;
         stage_ff <= mds_pkg::STAGE_IDLE;
         count_ff <= 8'd0;
         pmode_ff <= mds_pkg::MODE_STOP;
         mode_ff  <= mds_pkg::MODE_STOP;
         speed_ff <= 2'd0;
         busy_ff  <= 1'b0;
      end else if (advance) begin
         dir_ff   <= dir_in;
         en_ff    <= en_in;
         hs_ff    <= hs_in;
         stage_ff <= stage_in;
         count_ff <= count_in;
         pmode_ff <= pmode_in;
         mode_ff  <= mode_in;
         speed_ff <= speed_in;
         busy_ff  <= busy_in;
      end
   end

   assign state.pin_left           = dir_ff[0];
   assign state.pin_right          = dir_ff[1];
   assign state.pin_front          = dir_ff[2];
   assign state.pin_back           = dir_ff[3];
   assign state.pin_enable         = en_ff;
   assign state.pin_high_speed     = hs_ff;
   assign state.committed_mode     = mode_ff;
   assign state.current_speed_code = speed_ff;
   assign state.sequence_busy      = busy_ff;

endmodule

// ===== hdl/motor_direction_sequencer.sv =====
// Top level of the motor direction sequencer: input register, core, handshake.
// Depends on mds_pkg, mds_if, mds_csr and mds_core.
//
//   channel   direction  carries
//   req_bus   in         opcode, mode, speed, temperature
//   rsp_bus   out        pin levels, committed mode, speed code, busy flag
//   csr_*     in         register writes, index 0..6, 8-bit data
//
// One word per cycle sustained while the response side is ready.
// The input register feeds the core, whose state registers form the response word.
// A stalled response holds the core; the input register keeps one word meanwhile.
// Synchronous reset restores pins, sequence state and registers to defaults.
module motor_direction_sequencer (
   input  logic              clock,
   input  logic              reset,
   mds_req_if.sink           req_bus,
   mds_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wr_data
);

   mds_pkg::cfg_type cfg;
   mds_pkg::rsp_type state;
   mds_pkg::req_type item_ff, item_in;
   logic             item_valid_ff;
   logic             rsp_valid_ff;
   logic             advance;

   assign advance       = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;

   always_comb begin
      item_in.opcode      = mds_pkg::opcode_type'(req_bus.opcode);
      item_in.mode        = req_bus.mode;
      item_in.speed       = req_bus.speed;
      item_in.temperature = req_bus.temperature;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            item_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         item_ff <= item_in;
      end
   end

   mds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   mds_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .state   (state)
   );

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.pin_left           = state.pin_left;
   assign rsp_bus.pin_right          = state.pin_right;
   assign rsp_bus.pin_front          = state.pin_front;
   assign rsp_bus.pin_back           = state.pin_back;
   assign rsp_bus.pin_enable         = state.pin_enable;
   assign rsp_bus.pin_high_speed     = state.pin_high_speed;
   assign rsp_bus.committed_mode     = state.committed_mode;
   assign rsp_bus.current_speed_code = state.current_speed_code;
   assign rsp_bus.sequence_busy      = state.sequence_busy;

endmodule

// ===== hdl/mds_checker.sv =====
// Port-level checks of the motor direction sequencer and their bind.
// Depends on mds_pkg, motor_direction_sequencer and mds_if.
module mds_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       pin_left,
   input logic       pin_right,
   input logic       pin_front,
   input logic       pin_back,
   input logic       pin_enable,
   input logic       pin_high_speed,
   input logic [2:0] committed_mode,
   input logic [1:0] current_speed_code,
   input logic       sequence_busy
);

   logic [3:0] dir;
   logic [9:0] rsp_word;

   assign dir      = {pin_back, pin_front, pin_right, pin_left};
   assign rsp_word = {dir, pin_enable, pin_high_speed, committed_mode, sequence_busy};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) &&
                                  $stable(current_speed_code))
      else $error("response word changed while stalled");

   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(dir))
      else $error("more than one direction pin raised");

   a_enable_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pin_enable |-> !sequence_busy &&
         ((pin_left && committed_mode == mds_pkg::MODE_LEFT) ||
          (pin_right && committed_mode == mds_pkg::MODE_RIGHT) ||
          (pin_front && committed_mode == mds_pkg::MODE_FRONT) ||
          (pin_back && committed_mode == mds_pkg::MODE_BACK)))
      else $error("enable without matching committed direction");

   a_fast_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pin_high_speed |-> current_speed_code == mds_pkg::SPEED_FAST)
      else $error("high speed pin without fast speed code");

endmodule

bind motor_direction_sequencer mds_checker u_mds_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .pin_left           (rsp_bus.pin_left),
   .pin_right          (rsp_bus.pin_right),
   .pin_front          (rsp_bus.pin_front),
   .pin_back           (rsp_bus.pin_back),
   .pin_enable         (rsp_bus.pin_enable),
   .pin_high_speed     (rsp_bus.pin_high_speed),
   .committed_mode     (rsp_bus.committed_mode),
   .current_speed_code (rsp_bus.current_speed_code),
   .sequence_busy      (rsp_bus.sequence_busy)
);

// ===== dv/testbench.sv =====
// Self-checking testbench of the motor direction sequencer: drives request words
// and register writes, predicts each response word and compares the whole word.
// Depends on mds_pkg, mds_if and motor_direction_sequencer under hdl.
module testbench;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DIRECTION,
      SEQ_ENABLE
   } seq_stage_type;

   localparam logic [2:0]  CFG_UNUSED  = 3'd7;
   localparam int unsigned STALL_LIMIT = 500;
   localparam int unsigned MAX_REPORTS = 10;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [2:0] csr_index;
   logic [7:0] csr_wr_data;

   mds_req_if req_bus ();
   mds_rsp_if rsp_bus ();

   motor_direction_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   logic [7:0]       csr_shadow [7];
   logic [3:0]       dir_levels     = '0;
   logic             motor_on       = 1'b0;
   logic             fast_on        = 1'b0;
   logic             seq_busy       = 1'b0;
   seq_stage_type    seq_stage      = SEQ_IDLE;
   logic [7:0]       ms_left        = '0;
   logic [2:0]       requested_mode = mds_pkg::MODE_STOP;
   logic [2:0]       settled_mode   = mds_pkg::MODE_STOP;
   logic [1:0]       speed_code     = '0;
   mds_pkg::rsp_type expected_pins [$];

   int unsigned mismatch_count = 0;
   int unsigned stalled_cycles = 0;
   int unsigned words_sent     = 0;
   bit          req_steady     = 1'b0;
   bit          rsp_steady     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned draw_gap(input bit steady);
      if (steady || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(1, 13);
   endfunction

   function automatic logic fast_allowed(input logic [7:0] temp);
      return speed_code == mds_pkg::SPEED_FAST
          && $signed(temp) >= $signed(csr_shadow[mds_pkg::CFG_TEMP_LOW])
          && $signed(temp) <= $signed(csr_shadow[mds_pkg::CFG_TEMP_HIGH]);
   endfunction

   function automatic void step_sequencer(input mds_pkg::req_type w);
      mds_pkg::rsp_type r;
      case (w.opcode)
         mds_pkg::OP_TICK: begin
            if (seq_stage != SEQ_IDLE) begin
               if (ms_left > 8'd1) begin
                  ms_left = ms_left - 8'd1;
               end else begin
                  ms_left = '0;
                  if (seq_stage == SEQ_ENABLE) begin
                     motor_on     = 1'b1;
                     settled_mode = requested_mode;
                     seq_busy     = 1'b0;
                     seq_stage    = SEQ_IDLE;
                  end else if (requested_mode == mds_pkg::MODE_STOP) begin
                     dir_levels   = '0;
                     motor_on     = 1'b0;
                     settled_mode = mds_pkg::MODE_STOP;
                     seq_busy     = 1'b0;
                     seq_stage    = SEQ_IDLE;
                  end else begin
                     dir_levels[requested_mode - 3'd1] = 1'b1;
                     seq_stage = SEQ_ENABLE;
                     ms_left   = csr_shadow[mds_pkg::CFG_ENABLE_DELAY];
                  end
               end
            end
         end
         mds_pkg::OP_MODE: begin
            dir_levels     = '0;
            motor_on       = 1'b0;
            seq_busy       = 1'b1;
            requested_mode = w.mode;
            seq_stage      = SEQ_DIRECTION;
            case (w.mode)
               mds_pkg::MODE_STOP:  ms_left = csr_shadow[mds_pkg::CFG_STOP_DELAY];
               mds_pkg::MODE_LEFT,
               mds_pkg::MODE_RIGHT: ms_left = csr_shadow[mds_pkg::CFG_SIDE_DELAY];
               mds_pkg::MODE_FRONT: ms_left = csr_shadow[mds_pkg::CFG_FRONT_DELAY];
               mds_pkg::MODE_BACK:  ms_left = csr_shadow[mds_pkg::CFG_BACK_DELAY];
               default: begin
                  seq_stage = SEQ_IDLE;
                  ms_left   = '0;
               end
            endcase
         end
         mds_pkg::OP_SPEED: begin
            speed_code = w.speed;
            fast_on    = fast_allowed(w.temperature);
         end
         default: fast_on = fast_allowed(w.temperature);
      endcase
      r.pin_left           = dir_levels[0];
      r.pin_right          = dir_levels[1];
      r.pin_front          = dir_levels[2];
      r.pin_back           = dir_levels[3];
      r.pin_enable         = motor_on;
      r.pin_high_speed     = fast_on;
      r.committed_mode     = settled_mode;
      r.current_speed_code = speed_code;
      r.sequence_busy      = seq_busy;
      expected_pins.push_back(r);
   endfunction

   function automatic string pins_text(input mds_pkg::rsp_type r);
      return $sformatf("L%0b R%0b F%0b B%0b en %0b fast %0b mode %0d speed %0d busy %0b",
                       r.pin_left, r.pin_right, r.pin_front, r.pin_back, r.pin_enable,
                       r.pin_high_speed, r.committed_mode, r.current_speed_code,
                       r.sequence_busy);
   endfunction

   always @(posedge clock) begin : monitor
      mds_pkg::rsp_type seen;
      mds_pkg::rsp_type want;
      mds_pkg::req_type word;
      bit               moved;
      moved = 1'b0;
      if (reset) begin
         stalled_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved                   = 1'b1;
            seen.pin_left           = rsp_bus.pin_left;
            seen.pin_right          = rsp_bus.pin_right;
            seen.pin_front          = rsp_bus.pin_front;
            seen.pin_back           = rsp_bus.pin_back;
            seen.pin_enable         = rsp_bus.pin_enable;
            seen.pin_high_speed     = rsp_bus.pin_high_speed;
            seen.committed_mode     = rsp_bus.committed_mode;
            seen.current_speed_code = rsp_bus.current_speed_code;
            seen.sequence_busy      = rsp_bus.sequence_busy;
            if (expected_pins.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response word: %s", pins_text(seen));
            end else begin
               want = expected_pins.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("response mismatch\n   expected %s\n   actual   %s",
                              pins_text(want), pins_text(seen));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved            = 1'b1;
            word.opcode      = mds_pkg::opcode_type'(req_bus.opcode);
            word.mode        = req_bus.mode;
            word.speed       = req_bus.speed;
            word.temperature = req_bus.temperature;
            step_sequencer(word);
         end
         stalled_cycles = moved ? 0 : stalled_cycles + 1;
      end
   end

   initial begin : watchdog
      @(posedge clock);
      while (stalled_cycles < STALL_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : response_sink
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_steady);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic send_word(input mds_pkg::req_type w);
      int unsigned gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= w.opcode;
      req_bus.mode        <= w.mode;
      req_bus.speed       <= w.speed;
      req_bus.temperature <= w.temperature;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_fields(input mds_pkg::opcode_type op, input logic [2:0] mode,
                              input logic [1:0] speed, input logic [7:0] temperature);
      mds_pkg::req_type w;
      w.opcode      = op;
      w.mode        = mode;
      w.speed       = speed;
      w.temperature = temperature;
      send_word(w);
   endtask

   // hold requests until every response word is back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_pins.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      if (index != CFG_UNUSED) csr_shadow[index] = value;
   endtask

   task automatic program_regs(input int stop_ms, input int side_ms, input int front_ms,
                               input int back_ms, input int enable_ms,
                               input int temp_low, input int temp_high);
      drain_responses();
      write_reg(mds_pkg::CFG_STOP_DELAY, 8'(stop_ms));
      write_reg(mds_pkg::CFG_SIDE_DELAY, 8'(side_ms));
      write_reg(mds_pkg::CFG_FRONT_DELAY, 8'(front_ms));
      write_reg(mds_pkg::CFG_BACK_DELAY, 8'(back_ms));
      write_reg(mds_pkg::CFG_ENABLE_DELAY, 8'(enable_ms));
      write_reg(mds_pkg::CFG_TEMP_LOW, 8'(temp_low));
      write_reg(mds_pkg::CFG_TEMP_HIGH, 8'(temp_high));
      write_reg(CFG_UNUSED, 8'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic pick_idling();
      req_steady = ($urandom_range(0, 3) == 0);
      rsp_steady = ($urandom_range(0, 3) == 0);
   endtask

   function automatic mds_pkg::req_type random_word(input mds_pkg::opcode_type op);
      mds_pkg::req_type w;
      w.opcode = op;
      w.mode   = 3'($urandom_range(0, 7));
      w.speed  = ($urandom_range(0, 1) == 0) ? mds_pkg::SPEED_FAST
                                             : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: w.temperature = csr_shadow[mds_pkg::CFG_TEMP_LOW]
                            + 8'($urandom_range(0, 2)) - 8'd1;
         1: w.temperature = csr_shadow[mds_pkg::CFG_TEMP_HIGH]
                            + 8'($urandom_range(0, 2)) - 8'd1;
         default: w.temperature = 8'($urandom);
      endcase
      return w;
   endfunction

   // ticks from a mode word until that mode is committed
   function automatic int unsigned settle_ticks(input logic [2:0] mode);
      int unsigned first;
      case (mode)
         mds_pkg::MODE_STOP:  first = csr_shadow[mds_pkg::CFG_STOP_DELAY];
         mds_pkg::MODE_LEFT,
         mds_pkg::MODE_RIGHT: first = csr_shadow[mds_pkg::CFG_SIDE_DELAY];
         mds_pkg::MODE_FRONT: first = csr_shadow[mds_pkg::CFG_FRONT_DELAY];
         mds_pkg::MODE_BACK:  first = csr_shadow[mds_pkg::CFG_BACK_DELAY];
         default:             return 0;
      endcase
      if (first == 0) first = 1;
      if (mode == mds_pkg::MODE_STOP) return first;
      return first + ((csr_shadow[mds_pkg::CFG_ENABLE_DELAY] == 0)
                      ? 1 : csr_shadow[mds_pkg::CFG_ENABLE_DELAY]);
   endfunction

   task automatic run_mode(input logic [2:0] mode, input int unsigned ticks);
      mds_pkg::req_type w;
      w      = random_word(mds_pkg::OP_MODE);
      w.mode = mode;
      send_word(w);
      repeat (ticks) begin
         if ($urandom_range(0, 4) == 0)
            send_word(random_word(($urandom_range(0, 1) == 0) ? mds_pkg::OP_SPEED
                                                               : mds_pkg::OP_UPDATE));
         send_word(random_word(mds_pkg::OP_TICK));
      end
   endtask

   task automatic run_sequences(input int unsigned n_words);
      int unsigned stop_at;
      int unsigned ticks;
      logic [2:0]  mode;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            mode  = 3'($urandom_range(0, 4));
            ticks = settle_ticks(mode) + $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, ticks);
            run_mode(mode, ticks);
         end else begin
            send_word(random_word(mds_pkg::opcode_type'($urandom_range(0, 3))));
         end
      end
   endtask

   task automatic test_reset_window();
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_BACK, mds_pkg::SPEED_FAST, -8'sd10);
      send_fields(mds_pkg::OP_UPDATE, mds_pkg::MODE_STOP, 2'd0, -8'sd11);
      send_fields(mds_pkg::OP_UPDATE, mds_pkg::MODE_LEFT, 2'd3, 8'sd40);
      send_fields(mds_pkg::OP_UPDATE, mds_pkg::MODE_RIGHT, 2'd1, 8'sd41);
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_STOP, 2'd1, 8'sd20);
   endtask

   task automatic test_reset_delays();
      pick_idling();
      run_mode(mds_pkg::MODE_LEFT, settle_ticks(mds_pkg::MODE_LEFT));
      run_mode(mds_pkg::MODE_STOP, settle_ticks(mds_pkg::MODE_STOP));
   endtask

   task automatic test_special_cases();
      program_regs(1, 1, 2, 1, 0, -128, 127);
      send_fields(mds_pkg::OP_UPDATE, 3'd7, 2'd3, 8'sd0);
      send_fields(mds_pkg::OP_SPEED, 3'd5, mds_pkg::SPEED_FAST, -8'sd128);
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_STOP, mds_pkg::SPEED_FAST, 8'sd127);
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_BACK, 2'd3, 8'sd0);
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_LEFT, 2'd1, 8'sd0);
      send_fields(mds_pkg::OP_SPEED, mds_pkg::MODE_FRONT, mds_pkg::SPEED_FAST, 8'sd5);
      send_fields(mds_pkg::OP_TICK, 3'd7, 2'd3, -8'sd1);
      send_fields(mds_pkg::OP_MODE, mds_pkg::MODE_LEFT, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_BACK, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd3, 8'sd3);
      send_fields(mds_pkg::OP_MODE, mds_pkg::MODE_RIGHT, 2'd3, -8'sd128);
      send_fields(mds_pkg::OP_TICK, 3'd6, mds_pkg::SPEED_FAST, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_LEFT, 2'd0, 8'sd127);
      send_fields(mds_pkg::OP_MODE, mds_pkg::MODE_FRONT, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_MODE, mds_pkg::MODE_BACK, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_MODE, 3'd5, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_MODE, 3'd7, mds_pkg::SPEED_FAST, 8'sd0);
      send_fields(mds_pkg::OP_MODE, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_TICK, mds_pkg::MODE_STOP, 2'd0, 8'sd0);
      send_fields(mds_pkg::OP_MODE, 3'd6, 2'd1, 8'sd0);
      send_fields(mds_pkg::OP_UPDATE, mds_pkg::MODE_STOP, 2'd0, -8'sd128);
   endtask

   task automatic test_short_delays();
      int low;
      pick_idling();
      low = int'($urandom_range(0, 40)) - 20;
      program_regs($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 4), $urandom_range(1, 4),
                   low, low + int'($urandom_range(0, 60)));
      run_sequences(15);
   endtask

   task automatic test_zero_delays_empty_window();
      int low;
      pick_idling();
      low = int'($urandom_range(10, 50));
      program_regs($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 3),
                   low, low - int'($urandom_range(1, 30)));
      run_sequences(15);
   endtask

   task automatic test_point_window();
      int point;
      pick_idling();
      point = int'($urandom_range(0, 255)) - 128;
      program_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 8), $urandom_range(1, 8), point, point);
      run_sequences(15);
   endtask

   task automatic test_full_window();
      pick_idling();
      program_regs($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                   $urandom_range(1, 2), $urandom_range(1, 2), -128, 127);
      run_sequences(15);
   endtask

   task automatic test_longest_delays();
      pick_idling();
      program_regs(255, 255, 255, 255, 255, 127, -128);
      run_mode(mds_pkg::MODE_BACK, 255);
      run_mode(mds_pkg::MODE_FRONT, 3);
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= '0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= mds_pkg::OP_TICK;
      req_bus.mode        <= mds_pkg::MODE_STOP;
      req_bus.speed       <= '0;
      req_bus.temperature <= '0;
      csr_shadow[mds_pkg::CFG_STOP_DELAY]   = mds_pkg::RST_STOP_DELAY;
      csr_shadow[mds_pkg::CFG_SIDE_DELAY]   = mds_pkg::RST_SIDE_DELAY;
      csr_shadow[mds_pkg::CFG_FRONT_DELAY]  = mds_pkg::RST_FRONT_DELAY;
      csr_shadow[mds_pkg::CFG_BACK_DELAY]   = mds_pkg::RST_BACK_DELAY;
      csr_shadow[mds_pkg::CFG_ENABLE_DELAY] = mds_pkg::RST_ENABLE_DELAY;
      csr_shadow[mds_pkg::CFG_TEMP_LOW]     = mds_pkg::RST_TEMP_LOW;
      csr_shadow[mds_pkg::CFG_TEMP_HIGH]    = mds_pkg::RST_TEMP_HIGH;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_reset_delays();
      test_special_cases();
      test_short_delays();
      test_zero_delays_empty_window();
      test_point_window();
      test_full_window();
      test_longest_delays();
      test_short_delays();

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_pins.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
